@@ rtl/b64enc_pkg.sv @@
// b64enc_pkg: shared types, constants and the character table of the base64 encoder
// no dependencies; used by every module of the encoder
package b64enc_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CHAR_W      = 7;
    localparam int unsigned SEXTET_W    = 6;
    localparam int unsigned GROUP_W     = 24;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h3D;

    typedef logic [1:0] t_held_count;
    typedef logic [1:0] t_char_idx;

    typedef struct packed {
        logic [GROUP_W-1:0] bits;
        logic [1:0]         pad;
        logic               last;
    } t_group;

    function automatic logic [CHAR_W-1:0] sextet_to_char(input logic [SEXTET_W-1:0] s);
        logic [CHAR_W-1:0] c;
        c = 7'h41;
        case (s) inside
            [6'd0:6'd25]:  c = 7'h41 + 7'(s);
            [6'd26:6'd51]: c = 7'h61 + 7'(s - 6'd26);
            [6'd52:6'd61]: c = 7'h30 + 7'(s - 6'd52);
            6'd62:         c = 7'h2B;
            default:       c = 7'h2F;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/b64enc_front.sv @@
// b64enc_front: accepts message bytes and assembles 24-bit groups with padding info
// depends on b64enc_pkg
module b64enc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [b64enc_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                          i_last_byte,
    input  logic                          i_q_full,
    output logic                          o_accept,
    output logic                          o_q_wr,
    output b64enc_pkg::t_group            o_q_data
);
    import b64enc_pkg::*;

    logic [15:0]  r_held_bytes;
    logic [15:0]  n_held_bytes;
    t_held_count  r_held_count;
    t_held_count  n_held_count;
    logic         w_complete;

    assign o_accept   = i_push && !i_q_full;
    assign w_complete = r_held_count[1] || i_last_byte;
    assign o_q_wr     = o_accept && w_complete;

    always_comb begin
        o_q_data.last = i_last_byte;
        case (r_held_count)
            2'd0: begin
                o_q_data.bits = {i_data_byte, 16'h0000};
                o_q_data.pad  = 2'd2;
            end
            2'd1: begin
                o_q_data.bits = {r_held_bytes[15:8], i_data_byte, 8'h00};
                o_q_data.pad  = 2'd1;
            end
            default: begin
                o_q_data.bits = {r_held_bytes, i_data_byte};
                o_q_data.pad  = 2'd0;
            end
        endcase
    end

    always_comb begin
        n_held_bytes = r_held_bytes;
        n_held_count = r_held_count;
        if (o_accept) begin
            if (w_complete) begin
                n_held_count = 2'd0;
            end else if (r_held_count == 2'd0) begin
                n_held_bytes = {i_data_byte, 8'h00};
                n_held_count = 2'd1;
            end else begin
                n_held_bytes = {r_held_bytes[15:8], i_data_byte};
                n_held_count = 2'd2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_count <= 2'd0;
        end else begin
            r_held_count <= n_held_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held_bytes <= n_held_bytes;
    end

endmodule

@@ rtl/b64enc_queue.sv @@
// b64enc_queue: short group queue between the byte front end and the character back end
// depends on b64enc_pkg
module b64enc_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  b64enc_pkg::t_group i_wr_data,
    output logic               o_full,
    input  logic               i_rd,
    output b64enc_pkg::t_group o_rd_data,
    output logic               o_valid
);
    import b64enc_pkg::*;

    t_group              r_entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic [QCNT_W-1:0]   n_count;

    assign o_full    = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_rd_data = r_entries[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_wr && !i_rd) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr && i_rd) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_rd) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_entries[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

@@ rtl/b64enc_back.sv @@
// b64enc_back: splits each queued group into four characters behind an output register
// depends on b64enc_pkg
module b64enc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  b64enc_pkg::t_group            i_q_data,
    input  logic                          i_q_valid,
    output logic                          o_q_rd,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic [b64enc_pkg::CHAR_W-1:0] o_out_char,
    output logic                          o_out_last
);
    import b64enc_pkg::*;

    t_char_idx          r_idx;
    logic               r_valid;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;
    logic               w_load;
    logic               w_final;
    logic [SEXTET_W-1:0] w_sextet;
    logic [CHAR_W-1:0]  w_char;

    assign w_load  = i_q_valid && (!r_valid || i_pop);
    assign w_final = (r_idx == 2'd3);
    assign o_q_rd  = w_load && w_final;

    always_comb begin
        case (r_idx)
            2'd0:    w_sextet = i_q_data.bits[23:18];
            2'd1:    w_sextet = i_q_data.bits[17:12];
            2'd2:    w_sextet = i_q_data.bits[11:6];
            default: w_sextet = i_q_data.bits[5:0];
        endcase
        if ((3'(r_idx) + 3'(i_q_data.pad)) >= 3'd4) begin
            w_char = PAD_CHAR;
        end else begin
            w_char = sextet_to_char(w_sextet);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_idx   <= r_idx + 1'b1;
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_char <= w_char;
            r_last <= i_q_data.last && w_final;
        end
    end

    assign o_empty    = !r_valid;
    assign o_out_char = r_char;
    assign o_out_last = r_last;

endmodule

@@ rtl/base64_stream_encoder.sv @@
// base64_stream_encoder: standard-alphabet base64 encoder with queue ports on both sides
// depends on b64enc_pkg, b64enc_front, b64enc_queue, b64enc_back
//
// Bytes go in one per cycle while o_full is low; every third byte, or the byte
// flagged last, turns into a 24-bit group that waits in a two-entry group queue.
// The back end puts out one character per cycle, while i_pop is high, from that
// queue through an output register, with '=' padding for a short final group and
// o_out_last on the fourth character of the final group. The character port sets
// the sustained rate, since every group turns into four characters. When the back
// end is idle, the first character of a group goes through the group queue entry
// and then the output register to the result ports after the edge that accepted
// the byte that completed it. o_full rises when both queue entries hold groups.
module base64_stream_encoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [b64enc_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                          i_last_byte,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [b64enc_pkg::CHAR_W-1:0] o_out_char,
    output logic                          o_out_last
);
    import b64enc_pkg::*;

    logic   w_accept;
    logic   w_q_wr;
    logic   w_q_full;
    logic   w_q_rd;
    logic   w_q_valid;
    t_group w_q_wr_data;
    t_group w_q_rd_data;

    assign o_full = !w_accept && i_push ? 1'b1 : w_q_full;

    b64enc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_q_full    (w_q_full),
        .o_accept    (w_accept),
        .o_q_wr      (w_q_wr),
        .o_q_data    (w_q_wr_data)
    );

    b64enc_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_q_wr),
        .i_wr_data (w_q_wr_data),
        .o_full    (w_q_full),
        .i_rd      (w_q_rd),
        .o_rd_data (w_q_rd_data),
        .o_valid   (w_q_valid)
    );

    b64enc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_data   (w_q_rd_data),
        .i_q_valid  (w_q_valid),
        .o_q_rd     (w_q_rd),
        .i_pop      (i_pop),
        .o_empty    (o_empty),
        .o_out_char (o_out_char),
        .o_out_last (o_out_last)
    );

endmodule

@@ tb/tb_top.sv @@
// tb_top: self-checking testbench for base64_stream_encoder, directed and random byte streams
// predicts every output character from its own encoder model and compares in order
// depends on b64enc_pkg and the encoder rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import b64enc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam string B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              fin;
    } t_enc_char;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_push = 1'b0;
    logic              o_full;
    logic [BYTE_W-1:0] i_data_byte = '0;
    logic              i_last_byte = 1'b0;
    logic              o_empty;
    logic              i_pop = 1'b0;
    logic [CHAR_W-1:0] o_out_char;
    logic              o_out_last;

    t_enc_char   pending_chars[$];
    logic [15:0] held_pair = '0;
    logic [1:0]  held_n = '0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_left = 0;
    int          err_cnt = 0;
    int unsigned cycle_cnt = 0;

    base64_stream_encoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_out_char  (o_out_char),
        .o_out_last  (o_out_last)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // encoder model: hold two bytes, emit four characters per group
    function automatic void encode_byte(logic [BYTE_W-1:0] b, logic fin);
        logic [GROUP_W-1:0] grp;
        int                 pad;
        logic [5:0]         sx;
        t_enc_char          e;
        if (held_n == 2'd0) begin
            if (!fin) begin
                held_pair = {b, 8'h00};
                held_n = 2'd1;
                return;
            end
            grp = {b, 16'h0000};
            pad = 2;
        end else if (held_n == 2'd1) begin
            if (!fin) begin
                held_pair[7:0] = b;
                held_n = 2'd2;
                return;
            end
            grp = {held_pair[15:8], b, 8'h00};
            pad = 1;
        end else begin
            grp = {held_pair, b};
            pad = 0;
        end
        for (int k = 0; k < 4; k++) begin
            sx = grp[18 - 6 * k +: 6];
            e.ch = (k >= 4 - pad) ? PAD_CHAR : CHAR_W'(B64_ALPHABET[sx]);
            e.fin = fin && (k == 3);
            pending_chars.push_back(e);
        end
        held_pair = '0;
        held_n = 2'd0;
    endfunction

    // receiver side: random pops, or a long hold-off when requested
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_pop <= 1'b0;
        end else begin
            i_pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && !o_empty) begin
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected word, got char %h last %b",
                         $time, o_out_char, o_out_last);
                err_cnt++;
            end else begin
                if (o_out_char !== pending_chars[0].ch) begin
                    $display("%0t: char mismatch, expected %h got %h",
                             $time, pending_chars[0].ch, o_out_char);
                    err_cnt++;
                end
                if (o_out_last !== pending_chars[0].fin) begin
                    $display("%0t: last flag mismatch, expected %b got %b",
                             $time, pending_chars[0].fin, o_out_last);
                    err_cnt++;
                end
                void'(pending_chars.pop_front());
            end
        end
    end

    task automatic send_byte(logic [BYTE_W-1:0] b, logic fin);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_push <= 1'b0;
            @(negedge i_clk);
        end
        i_push <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= fin;
        do @(posedge i_clk); while (o_full);
        encode_byte(b, fin);
    endtask

    task automatic send_message(int len);
        for (int i = 0; i < len; i++) begin
            send_byte(BYTE_W'($urandom_range(255)), i == len - 1);
        end
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        i_push <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // one-byte message, two pad chars
        send_byte(8'hFF, 1'b1);
        // two-byte message, one pad char
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        // full groups hitting the table extremes
        send_byte(8'hFB, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBE, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        // mid-message group followed by a short tail
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b0);
        send_byte(8'h41, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h10, 1'b0);
        send_byte(8'h83, 1'b0);
        send_byte(8'h10, 1'b0);
        send_byte(8'h51, 1'b1);
        wait_for_drain();
    endtask

    task automatic test_random_phase(int s_idle, int r_idle, int n_bytes);
        int sent;
        int len;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        sent = 0;
        while (sent < n_bytes) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 7);
            send_message(len);
            sent += len;
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left = 120;
        send_message(30);
        wait_for_drain();
    endtask

    task automatic test_sender_pause();
        send_idle_pct = 10;
        recv_idle_pct = 30;
        send_message(5);
        wait_for_drain();
        send_message(4);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_phase(21, 85, 100);
        test_random_phase(85, 21, 100);
        test_random_phase(0, 0, 100);
        test_backpressure();
        test_sender_pause();
        wait_for_drain();
        if (err_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/b64enc_pkg.sv
rtl/b64enc_front.sv
rtl/b64enc_queue.sv
rtl/b64enc_back.sv
rtl/base64_stream_encoder.sv
tb/tb_top.sv
